[hdl/unordered_list_swap_remove_assert.svh]
// Assertion macros shared by the list RTL.
// No dependencies; files that assert include this header by name.
`ifndef UNORDERED_LIST_SWAP_REMOVE_ASSERT_SVH
`define UNORDERED_LIST_SWAP_REMOVE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ULSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ULSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ulsr_pkg.sv]
// Types and constants for the unordered list with swap-remove.
// No dependencies; used by the controller and the top level.
package ulsr_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  localparam int VALUE_W = 32;
  localparam int FIDX_W  = 4;
  localparam int ECNT_W  = 5;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Register indexes of the configuration space
  localparam logic REG_LIST_LIMIT = 1'b0;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [VALUE_W-1:0]  value;
  } req_beat_t;

  typedef struct packed {
    status_t            status;
    logic [FIDX_W-1:0]  found_index;
    logic [ECNT_W-1:0]  entry_count;
  } rsp_beat_t;

endpackage

[hdl/unordered_list_swap_remove.sv]
// Top level of the bounded unordered list with swap-remove.
// Depends on ulsr_pkg, ulsr_ctrl and ulsr_ram.
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+---------------------
//  req      | req_valid, req_ready, req                 | opcode, value
//  rsp      | rsp_valid, rsp_ready, rsp                 | status, index, count
//  cfg      | psel, penable, pwrite, paddr, pwdata, ... | list_limit at 0x0
//
// One beat at a time. Insert, no-op and the full/empty cases go to the result
// state straight from acceptance. Search reads entries from 0 up to a hit or
// the last entry; remove adds a step that moves the last entry into the hole.
// The bound is the single RAM read port: one entry per cycle.
// Reset is synchronous and empties the list; entry storage is not cleared.
// A stalled rsp beat holds in its register; the next req is taken meanwhile.
module unordered_list_swap_remove #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ulsr_pkg::req_beat_t  req,
  // result channel
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output ulsr_pkg::rsp_beat_t  rsp,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ulsr_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  logic [LIMIT_W-1:0]  list_limit;
  logic                cfg_write;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [VALUE_W-1:0]  mem_rdata;

  // Config space: word index is paddr[2]; only list_limit exists.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LIST_LIMIT);
  assign prdata    = (paddr[2] == REG_LIST_LIMIT) ? 32'(list_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      list_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Sequencer: owns count, the scan and the result register
  ulsr_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .list_limit (list_limit),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Entry storage, one read per cycle with registered read data
  ulsr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[hdl/ulsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ulsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ulsr_ctrl.sv]
// Sequencer for the list: insert, linear scan, swap-remove, result register.
// Depends on ulsr_pkg and the assertion header; drives the entry RAM ports.
`include "unordered_list_swap_remove_assert.svh"

module ulsr_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ulsr_pkg::LIMIT_W-1:0] list_limit,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ulsr_pkg::req_beat_t         req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output ulsr_pkg::rsp_beat_t         rsp,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [ulsr_pkg::VALUE_W-1:0] mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [ulsr_pkg::VALUE_W-1:0] mem_rdata
);
  import ulsr_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        hit_idx;
  logic [VALUE_W-1:0]   key;
  logic                 is_remove;
  status_t              res_status;
  logic [IW-1:0]        res_idx;

  logic                 accept;
  logic                 full;
  logic                 match;
  logic                 at_last;
  logic                 rsp_load;
  logic [LW-1:0]        limit_eff;
  logic [IW-1:0]        last_idx;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign limit_eff = (LW'(list_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(list_limit);
  assign full      = (LW'(count) >= limit_eff);
  assign last_idx  = IW'(count - CW'(1));
  assign match     = (mem_rdata == key);
  assign at_last   = (CW'(rd_idx) == (count - CW'(1)));

  // Write port: append on insert, last entry moved into the hole on remove
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IW'(count);
    mem_wdata = req.value;
    if (state == S_MOVE) begin
      mem_we    = 1'b1;
      mem_waddr = hit_idx;
      mem_wdata = mem_rdata;
    end else if (accept && (req.opcode == OP_INSERT) && !full) begin
      mem_we = 1'b1;
    end
  end

  // Read port: scan ahead one entry, or fetch the last entry on a remove hit
  always_comb begin
    mem_raddr = '0;
    if (state == S_SCAN) begin
      mem_raddr = (match && is_remove) ? last_idx : rd_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Result register: load a finished beat, else drop valid once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key       <= req.value;
            is_remove <= (req.opcode == OP_REMOVE);
            rd_idx    <= '0;
            case (req.opcode)
              OP_INSERT: begin
                state <= S_DONE;
                if (full) begin
                  res_status <= ST_FULL;
                  res_idx    <= '0;
                end else begin
                  res_status <= ST_OK;
                  res_idx    <= IW'(count);
                  count      <= count + CW'(1);
                end
              end
              OP_SEARCH: begin
                res_idx <= '0;
                if (count == '0) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                res_idx <= '0;
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              default: begin
                res_status <= ST_OK;
                res_idx    <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            res_idx <= rd_idx;
            hit_idx <= rd_idx;
            state   <= is_remove ? S_MOVE : S_DONE;
          end else if (at_last) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            rd_idx <= rd_idx + IW'(1);
          end
        end
        S_MOVE: begin
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.status      <= res_status;
            rsp.found_index <= FIDX_W'(res_idx);
            rsp.entry_count <= ECNT_W'(count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ULSR_ASSERT_NEXT(a_one_at_a_time, clk, rst, accept, !req_ready, "item accepted while busy")
  `ULSR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "count over capacity")
  `ULSR_ASSERT_NOW(a_scan_nonempty, clk, rst, state == S_SCAN, count != '0, "scan of empty list")
  `ULSR_ASSERT_NEXT(a_move_shrinks, clk, rst, state == S_MOVE,
                    count == $past(count) - CW'(1), "remove did not shrink count")

endmodule
